/* rtl/core/tpsm_pkg.sv */
// Shared types and constants for the touch point smoother and mapper.
// Depends on nothing; imported by touch_point_smoother_mapper, tpsm_point_checker and the testbench.
package tpsm_pkg;

   // Smoothing window and screen geometry
   localparam int WINDOW   = 4;
   localparam int SLOT_W   = $clog2(WINDOW);
   localparam int RAW_W    = 12;
   localparam int SUM_W    = RAW_W + SLOT_W;
   localparam int SCREEN_W = 320;
   localparam int SCREEN_H = 240;
   localparam int PIX_W    = 9;

   // Configuration register map, one 64-bit slot per register
   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;

   typedef enum logic [2:0] {
      CSR_GAIN_X     = 3'd0,
      CSR_OFFSET_X   = 3'd1,
      CSR_GAIN_Y     = 3'd2,
      CSR_OFFSET_Y   = 3'd3,
      CSR_SCAN_RECT  = 3'd4,
      CSR_BACK_RECT  = 3'd5,
      CSR_LIST_TOP   = 3'd6,
      CSR_ROW_HEIGHT = 3'd7
   } csr_index_type;

   // Input beat: one touch-panel sample
   typedef struct packed {
      logic        touched;
      logic [11:0] raw_x;
      logic [11:0] raw_y;
      logic [7:0]  network_count;
   } req_payload_type;

   // Result beat
   typedef struct packed {
      logic       pressed;
      logic [8:0] screen_x;
      logic [7:0] screen_y;
      logic       scan_hit;
      logic       back_hit;
      logic       row_valid;
      logic [7:0] row_index;
   } rsp_payload_type;

endpackage

/* rtl/core/touch_point_smoother_mapper.sv */
// Touch point smoother and mapper: history, averaging, calibration, hit tests, list row.
// Depends on tpsm_pkg for payload types, register codes and screen geometry.

// One sample is taken when req_ready is high, which is only while the
// sequencer is idle. An untouched sample goes from the accept cycle
// straight to loading the result register. A touched sample passes through
// the accept cycle, accumulation of the WINDOW history entries through the
// history adder, two multiply/map passes through the single 20x13 signed
// multiplier shared by both axes, the row setup state and the restoring row
// divider over all PIX_W quotient bits, and the load of the result register.
// The divider is skipped when the point lies above the list top or the row
// height is zero. The result register lets a new sample be accepted while a
// result still waits on rsp_ready; the next sample then holds in its finish
// state until that result is taken. Configuration goes through a 64-bit
// APB-style port with register i at byte address 8*i; pready is tied high.
module touch_point_smoother_mapper
   import tpsm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_payload_type       req_payload,

   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_payload_type       rsp_payload,

   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACC,
      ST_MUL,
      ST_MAP,
      ST_ROW,
      ST_DIV,
      ST_FINISH
   } state_type;

   localparam int CNT_W = 4;
   localparam logic signed [17:0] X_MAX = 18'(SCREEN_W - 1);
   localparam logic signed [17:0] Y_MAX = 18'(SCREEN_H - 1);

   // Configuration registers
   logic signed [19:0] gain_x_ff, gain_y_ff;
   logic signed [26:0] offset_x_ff, offset_y_ff;
   logic [35:0]        scan_rect_ff, back_rect_ff;
   logic [7:0]         list_top_ff, row_height_ff;

   // Sequencer and datapath registers
   state_type          state_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic               axis_ff;
   logic [SLOT_W-1:0]  slot_ff;
   logic [RAW_W-1:0]   xh_ff [WINDOW];
   logic [RAW_W-1:0]   yh_ff [WINDOW];
   logic [SUM_W-1:0]   sumx_ff, sumy_ff;
   logic signed [32:0] prod_ff;
   logic [PIX_W-1:0]   sx_ff, sy_ff;
   logic [7:0]         ncount_ff;
   logic               touch_ff;
   logic [PIX_W-1:0]   rem_ff, quo_ff;
   logic               row_ok_ff;
   logic               rsp_valid_ff;
   rsp_payload_type    rsp_ff;

   // Combinational helpers
   logic               csr_write;
   csr_index_type      csr_index;
   logic [RAW_W-1:0]   avg_in;
   logic signed [32:0] prod_in;
   logic signed [33:0] q_in;
   logic signed [17:0] p_in;
   logic signed [17:0] lim_in;
   logic [PIX_W-1:0]   pix_in;
   logic [PIX_W:0]     rem_sh_in;
   logic [PIX_W:0]     diff_in;
   logic               load_rsp;
   rsp_payload_type    rsp_in;

   function automatic logic in_rect(input logic [35:0] r, input logic [PIX_W-1:0] x,
                                    input logic [PIX_W-1:0] y);
      logic [9:0] xr;
      logic [9:0] yb;
      xr = {1'b0, r[8:0]} + {1'b0, r[26:18]};
      yb = {1'b0, r[17:9]} + {1'b0, r[35:27]};
      return (x >= r[8:0]) && ({1'b0, x} <= xr) && (y >= r[17:9]) && ({1'b0, y} <= yb);
   endfunction

   // Configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_index_type'(csr_paddr[CSR_ADDR_W-1:3]);

   always_comb begin
      case (csr_index)
         CSR_GAIN_X:     csr_prdata = 64'(signed'(gain_x_ff));
         CSR_OFFSET_X:   csr_prdata = 64'(signed'(offset_x_ff));
         CSR_GAIN_Y:     csr_prdata = 64'(signed'(gain_y_ff));
         CSR_OFFSET_Y:   csr_prdata = 64'(signed'(offset_y_ff));
         CSR_SCAN_RECT:  csr_prdata = {28'd0, scan_rect_ff};
         CSR_BACK_RECT:  csr_prdata = {28'd0, back_rect_ff};
         CSR_LIST_TOP:   csr_prdata = {56'd0, list_top_ff};
         CSR_ROW_HEIGHT: csr_prdata = {56'd0, row_height_ff};
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_x_ff     <= 20'sd5120;
         offset_x_ff   <= '0;
         gain_y_ff     <= 20'sd3840;
         offset_y_ff   <= '0;
         scan_rect_ff  <= '0;
         back_rect_ff  <= '0;
         list_top_ff   <= '0;
         row_height_ff <= 8'd20;
      end else if (csr_write) begin
         case (csr_index)
            CSR_GAIN_X:     gain_x_ff     <= csr_pwdata[19:0];
            CSR_OFFSET_X:   offset_x_ff   <= csr_pwdata[26:0];
            CSR_GAIN_Y:     gain_y_ff     <= csr_pwdata[19:0];
            CSR_OFFSET_Y:   offset_y_ff   <= csr_pwdata[26:0];
            CSR_SCAN_RECT:  scan_rect_ff  <= csr_pwdata[35:0];
            CSR_BACK_RECT:  back_rect_ff  <= csr_pwdata[35:0];
            CSR_LIST_TOP:   list_top_ff   <= csr_pwdata[7:0];
            CSR_ROW_HEIGHT: row_height_ff <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   // Window average: the window is a power of two, so drop the low sum bits
   assign avg_in  = axis_ff ? sumy_ff[SUM_W-1:SLOT_W] : sumx_ff[SUM_W-1:SLOT_W];

   // Shared multiplier, one axis per pass
   assign prod_in = (axis_ff ? gain_y_ff : gain_x_ff) * signed'({1'b0, avg_in});

   // Add offset, floor to a pixel and clamp to the screen
   always_comb begin
      q_in   = 34'(prod_ff) + 34'(axis_ff ? offset_y_ff : offset_x_ff);
      p_in   = q_in[33:16];
      lim_in = axis_ff ? Y_MAX : X_MAX;
      if (p_in[17]) begin
         pix_in = '0;
      end else if (p_in > lim_in) begin
         pix_in = lim_in[PIX_W-1:0];
      end else begin
         pix_in = p_in[PIX_W-1:0];
      end
   end

   // Restoring divider step for the list row
   assign rem_sh_in = {rem_ff, quo_ff[PIX_W-1]};
   assign diff_in   = rem_sh_in - {2'b00, row_height_ff};

   // Result beat assembly
   always_comb begin
      rsp_in = '0;
      if (touch_ff) begin
         rsp_in.pressed  = 1'b1;
         rsp_in.screen_x = sx_ff;
         rsp_in.screen_y = sy_ff[7:0];
         rsp_in.scan_hit = in_rect(scan_rect_ff, sx_ff, sy_ff);
         rsp_in.back_hit = in_rect(back_rect_ff, sx_ff, sy_ff);
         if (row_ok_ff && (quo_ff < {1'b0, ncount_ff})) begin
            rsp_in.row_valid = 1'b1;
            rsp_in.row_index = quo_ff[7:0];
         end
      end
   end

   assign req_ready   = (state_ff == ST_IDLE);
   assign load_rsp    = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Sequencer, history and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         axis_ff      <= 1'b0;
         slot_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < WINDOW; i++) begin
            xh_ff[i] <= '0;
            yh_ff[i] <= '0;
         end
      end else begin
         // drop a delivered result beat unless a new one replaces it
         if (rsp_valid_ff && rsp_ready && !load_rsp) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  touch_ff  <= req_payload.touched;
                  ncount_ff <= req_payload.network_count;
                  if (req_payload.touched) begin
                     xh_ff[slot_ff] <= req_payload.raw_x;
                     yh_ff[slot_ff] <= req_payload.raw_y;
                     slot_ff        <= slot_ff + 1'b1;
                     sumx_ff        <= '0;
                     sumy_ff        <= '0;
                     cnt_ff         <= '0;
                     state_ff       <= ST_ACC;
                  end else begin
                     state_ff <= ST_FINISH;
                  end
               end
            end
            ST_ACC: begin
               sumx_ff <= sumx_ff + SUM_W'(xh_ff[cnt_ff[SLOT_W-1:0]]);
               sumy_ff <= sumy_ff + SUM_W'(yh_ff[cnt_ff[SLOT_W-1:0]]);
               cnt_ff  <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(WINDOW - 1)) begin
                  axis_ff  <= 1'b0;
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               prod_ff  <= prod_in;
               state_ff <= ST_MAP;
            end
            ST_MAP: begin
               if (axis_ff) begin
                  sy_ff    <= pix_in;
                  state_ff <= ST_ROW;
               end else begin
                  sx_ff    <= pix_in;
                  axis_ff  <= 1'b1;
                  state_ff <= ST_MUL;
               end
            end
            ST_ROW: begin
               // divide only for a point at or below the list top with a nonzero row height
               if ((sy_ff >= PIX_W'(list_top_ff)) && (row_height_ff != 8'd0)) begin
                  quo_ff    <= sy_ff - PIX_W'(list_top_ff);
                  rem_ff    <= '0;
                  cnt_ff    <= '0;
                  row_ok_ff <= 1'b1;
                  state_ff  <= ST_DIV;
               end else begin
                  row_ok_ff <= 1'b0;
                  state_ff  <= ST_FINISH;
               end
            end
            ST_DIV: begin
               if (!diff_in[PIX_W]) begin
                  rem_ff <= diff_in[PIX_W-1:0];
                  quo_ff <= {quo_ff[PIX_W-2:0], 1'b1};
               end else begin
                  rem_ff <= rem_sh_in[PIX_W-1:0];
                  quo_ff <= {quo_ff[PIX_W-2:0], 1'b0};
               end
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(PIX_W - 1)) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (load_rsp) begin
                  rsp_ff       <= rsp_in;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

/* verif/tpsm_point_checker.sv */
// Result checker for touch_point_smoother_mapper: watches the sample, result and
// register channels, predicts each result and compares it field by field.
// Depends on tpsm_pkg for payload types, register codes and screen geometry.
`timescale 1ns / 1ps

module tpsm_point_checker
   import tpsm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  req_payload_type       req_payload,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rsp_payload_type       rsp_payload,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic                  csr_pready,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output int                    fail_count,
   output int                    points_pending
);

   // Shadow of the calibration registers
   logic signed [19:0] cal_gain_x;
   logic signed [26:0] cal_off_x;
   logic signed [19:0] cal_gain_y;
   logic signed [26:0] cal_off_y;
   logic [35:0]        scan_box;
   logic [35:0]        back_box;
   logic [7:0]         list_row0;
   logic [7:0]         row_pitch;

   // Shadow of the smoothing histories
   logic [RAW_W-1:0]   hist_x [WINDOW];
   logic [RAW_W-1:0]   hist_y [WINDOW];
   int                 write_pos;

   rsp_payload_type    expected_points [$];
   int                 mismatches = 0;
   int                 waiting = 0;

   assign fail_count     = mismatches;
   assign points_pending = waiting;

   task automatic report_mismatch(string msg);
      $display("%0t: MISMATCH %s", $time, msg);
      mismatches++;
   endtask

   // Q.16 gain and offset, floor toward minus infinity, clamp to the screen
   function automatic int map_axis(int avg, logic signed [19:0] gain,
                                   logic signed [26:0] offset, int limit);
      longint q;
      longint p;
      q = longint'(gain) * longint'(avg) + longint'(offset);
      p = q >>> 16;
      if (p < 0) p = 0;
      if (p > limit - 1) p = limit - 1;
      return int'(p);
   endfunction

   // Inclusive rectangle test; fields are left, top, width, height from bit 0 up
   function automatic bit in_box(logic [35:0] box, int x, int y);
      int l, t, w, h;
      l = box[8:0];
      t = box[17:9];
      w = box[26:18];
      h = box[35:27];
      return x >= l && x <= l + w && y >= t && y <= t + h;
   endfunction

   // Push the sample into the histories, then average, map and hit-test
   function automatic rsp_payload_type predict_point(req_payload_type s);
      rsp_payload_type r;
      int sum_x, sum_y, px, py, top_row, pitch, row;
      r = '0;
      if (s.touched) begin
         hist_x[write_pos] = s.raw_x;
         hist_y[write_pos] = s.raw_y;
         write_pos = (write_pos + 1) % WINDOW;
         sum_x = 0;
         sum_y = 0;
         for (int i = 0; i < WINDOW; i++) begin
            sum_x += hist_x[i];
            sum_y += hist_y[i];
         end
         px = map_axis(sum_x / WINDOW, cal_gain_x, cal_off_x, SCREEN_W);
         py = map_axis(sum_y / WINDOW, cal_gain_y, cal_off_y, SCREEN_H);
         r.pressed  = 1'b1;
         r.screen_x = px[8:0];
         r.screen_y = py[7:0];
         r.scan_hit = in_box(scan_box, px, py);
         r.back_hit = in_box(back_box, px, py);
         top_row = list_row0;
         pitch   = row_pitch;
         // no selection above the list, with zero pitch, or past the count
         if (py >= top_row && pitch != 0) begin
            row = (py - top_row) / pitch;
            if (row < int'(s.network_count)) begin
               r.row_valid = 1'b1;
               r.row_index = row[7:0];
            end
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         cal_gain_x = 20'sd5120;
         cal_off_x  = '0;
         cal_gain_y = 20'sd3840;
         cal_off_y  = '0;
         scan_box   = '0;
         back_box   = '0;
         list_row0  = '0;
         row_pitch  = 8'd20;
         for (int i = 0; i < WINDOW; i++) begin
            hist_x[i] = '0;
            hist_y[i] = '0;
         end
         write_pos = 0;
         expected_points.delete();
      end else begin
         // compare a result beat with the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (expected_points.size() == 0) begin
               report_mismatch($sformatf("result beat %h with no sample pending",
                                         rsp_payload));
            end else begin
               want = expected_points.pop_front();
               if (rsp_payload.pressed !== want.pressed)
                  report_mismatch($sformatf("pressed got %0d want %0d",
                                            rsp_payload.pressed, want.pressed));
               if (rsp_payload.screen_x !== want.screen_x)
                  report_mismatch($sformatf("screen_x got %0d want %0d",
                                            rsp_payload.screen_x, want.screen_x));
               if (rsp_payload.screen_y !== want.screen_y)
                  report_mismatch($sformatf("screen_y got %0d want %0d",
                                            rsp_payload.screen_y, want.screen_y));
               if (rsp_payload.scan_hit !== want.scan_hit)
                  report_mismatch($sformatf("scan_hit got %0d want %0d",
                                            rsp_payload.scan_hit, want.scan_hit));
               if (rsp_payload.back_hit !== want.back_hit)
                  report_mismatch($sformatf("back_hit got %0d want %0d",
                                            rsp_payload.back_hit, want.back_hit));
               if (rsp_payload.row_valid !== want.row_valid)
                  report_mismatch($sformatf("row_valid got %0d want %0d",
                                            rsp_payload.row_valid, want.row_valid));
               if (rsp_payload.row_index !== want.row_index)
                  report_mismatch($sformatf("row_index got %0d want %0d",
                                            rsp_payload.row_index, want.row_index));
            end
         end

         // predict each accepted sample beat
         if (req_valid && req_ready)
            expected_points.push_back(predict_point(req_payload));

         // track register writes
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_index_type'(csr_paddr[5:3]))
               CSR_GAIN_X:     cal_gain_x = csr_pwdata[19:0];
               CSR_OFFSET_X:   cal_off_x  = csr_pwdata[26:0];
               CSR_GAIN_Y:     cal_gain_y = csr_pwdata[19:0];
               CSR_OFFSET_Y:   cal_off_y  = csr_pwdata[26:0];
               CSR_SCAN_RECT:  scan_box   = csr_pwdata[35:0];
               CSR_BACK_RECT:  back_box   = csr_pwdata[35:0];
               CSR_LIST_TOP:   list_row0  = csr_pwdata[7:0];
               CSR_ROW_HEIGHT: row_pitch  = csr_pwdata[7:0];
               default: ;
            endcase
         end
      end
      waiting = expected_points.size();
   end

endmodule

/* verif/touch_point_smoother_mapper_tb.sv */
// Testbench top for touch_point_smoother_mapper: clock, reset, sample and
// register stimulus, result back-pressure and the final verdict.
// Depends on tpsm_pkg, the block itself and tpsm_point_checker.
`timescale 1ns / 1ps

module touch_point_smoother_mapper_tb;
   import tpsm_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASES      = 6;
   localparam int PHASE_ITEMS = 72;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_payload_type       req_payload;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_payload_type       rsp_payload;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int fail_count;
   int points_pending;
   int cycle_count = 0;
   int samples_sent = 0;
   bit no_gaps = 1'b0;

   touch_point_smoother_mapper u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   tpsm_point_checker u_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_payload    (rsp_payload),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_pready     (csr_pready),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .fail_count     (fail_count),
      .points_pending (points_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Mostly short gaps, some long ones, none while a burst is running
   function automatic int pick_gap();
      int r;
      if (no_gaps) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Stall the result side at random
   initial begin
      int stall;
      rsp_ready = 1'b1;
      forever begin
         stall = pick_gap();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
            rsp_ready <= 1'b1;
         end
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
   end

   // One register write: setup, access, then idle with the bus released
   task automatic write_reg(csr_index_type idx, longint value, int width);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= value & ((64'd1 << width) - 64'd1);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   function automatic longint pack_box(int l, int t, int w, int h);
      return longint'(l[8:0]) | (longint'(h[8:0]) << 27) |
             (longint'(w[8:0]) << 18) | (longint'(t[8:0]) << 9);
   endfunction

   // Send one sample beat and hold it until accepted
   task automatic send_sample(bit touched, int rx, int ry, int nc);
      int gap;
      req_payload_type s;
      gap = pick_gap();
      s.touched       = touched;
      s.raw_x         = rx[11:0];
      s.raw_y         = ry[11:0];
      s.network_count = nc[7:0];
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= s;
      do @(posedge clock); while (!req_ready);
      samples_sent++;
      @(negedge clock);
   endtask

   // Drop valid and wait until every predicted result has come back
   task automatic drain();
      req_valid <= 1'b0;
      while (points_pending != 0) @(negedge clock);
   endtask

   // New calibration: normal, mirrored, raw random or near-flat mapping
   task automatic random_calibration();
      int kind, v;
      kind = $urandom_range(0, 3);
      case (kind)
         0: begin
            write_reg(CSR_GAIN_X, $urandom_range(4000, 6500), 20);
            v = $urandom_range(0, 80 << 16);
            write_reg(CSR_OFFSET_X, v - (40 << 16), 27);
            write_reg(CSR_GAIN_Y, $urandom_range(3000, 5000), 20);
            v = $urandom_range(0, 80 << 16);
            write_reg(CSR_OFFSET_Y, v - (40 << 16), 27);
         end
         1: begin
            v = $urandom_range(4000, 6500);
            write_reg(CSR_GAIN_X, -v, 20);
            v = $urandom_range(0, 40 << 16);
            write_reg(CSR_OFFSET_X, (SCREEN_W << 16) + v - (20 << 16), 27);
            v = $urandom_range(3000, 5000);
            write_reg(CSR_GAIN_Y, -v, 20);
            v = $urandom_range(0, 40 << 16);
            write_reg(CSR_OFFSET_Y, (SCREEN_H << 16) + v - (20 << 16), 27);
         end
         2: begin
            write_reg(CSR_GAIN_X, $urandom(), 20);
            write_reg(CSR_OFFSET_X, $urandom(), 27);
            write_reg(CSR_GAIN_Y, $urandom(), 20);
            write_reg(CSR_OFFSET_Y, $urandom(), 27);
         end
         default: begin
            v = $urandom_range(0, 300);
            write_reg(CSR_GAIN_X, v - 150, 20);
            v = $urandom_range(0, 800 << 16);
            write_reg(CSR_OFFSET_X, v - (400 << 16), 27);
            v = $urandom_range(0, 300);
            write_reg(CSR_GAIN_Y, v - 150, 20);
            v = $urandom_range(0, 600 << 16);
            write_reg(CSR_OFFSET_Y, v - (300 << 16), 27);
         end
      endcase

      // buttons mostly on screen, sometimes anywhere in the field range
      if ($urandom_range(0, 3) != 0) begin
         write_reg(CSR_SCAN_RECT, pack_box($urandom_range(0, 319), $urandom_range(0, 239),
                                           $urandom_range(0, 100), $urandom_range(0, 80)), 36);
         write_reg(CSR_BACK_RECT, pack_box($urandom_range(0, 319), $urandom_range(0, 239),
                                           $urandom_range(0, 100), $urandom_range(0, 80)), 36);
      end else begin
         write_reg(CSR_SCAN_RECT, {$urandom(), $urandom()}, 36);
         write_reg(CSR_BACK_RECT, {$urandom(), $urandom()}, 36);
      end

      write_reg(CSR_LIST_TOP, $urandom_range(0, 239), 8);
      if ($urandom_range(0, 2) == 0)
         write_reg(CSR_ROW_HEIGHT, $urandom_range(1, 239), 8);
      else
         write_reg(CSR_ROW_HEIGHT, $urandom_range(8, 40), 8);
   endtask

   // A finger held near one point, with lifts and spikes mixed in
   task automatic run_gesture();
      int cx, cy, len, nc, r, vx, vy;
      cx  = $urandom_range(0, 4095);
      cy  = $urandom_range(0, 4095);
      len = $urandom_range(3, 12);
      nc  = ($urandom_range(0, 9) < 3) ? $urandom_range(0, 255) : $urandom_range(0, 16);
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < len; k++) begin
         r = $urandom_range(0, 99);
         if (r < 8) begin
            send_sample(1'b0, $urandom_range(0, 4095), $urandom_range(0, 4095), nc);
         end else if (r < 12) begin
            send_sample(1'b1, $urandom_range(0, 4095), $urandom_range(0, 4095), nc);
         end else begin
            vx = cx + $urandom_range(0, 32) - 16;
            vy = cy + $urandom_range(0, 32) - 16;
            vx = (vx < 0) ? 0 : ((vx > 4095) ? 4095 : vx);
            vy = (vy < 0) ? 0 : ((vy > 4095) ? 4095 : vy);
            send_sample(1'b1, vx, vy, nc);
         end
      end
      no_gaps = 1'b0;
   endtask

   initial begin
      int start;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset calibration: idle sample, full-scale fill, then zero fill
      send_sample(1'b0, 4095, 4095, 255);
      repeat (4) send_sample(1'b1, 4095, 4095, 255);
      send_sample(1'b0, 0, 0, 255);
      repeat (4) send_sample(1'b1, 0, 0, 0);
      drain();

      // Extreme gains and offsets, full-screen back button, zero row height
      write_reg(CSR_GAIN_X, -524288, 20);
      write_reg(CSR_OFFSET_X, 67108863, 27);
      write_reg(CSR_GAIN_Y, 524287, 20);
      write_reg(CSR_OFFSET_Y, -67108864, 27);
      write_reg(CSR_SCAN_RECT, 64'hF_FFFF_FFFF, 36);
      write_reg(CSR_BACK_RECT, pack_box(0, 0, 319, 239), 36);
      write_reg(CSR_LIST_TOP, 239, 8);
      write_reg(CSR_ROW_HEIGHT, 0, 8);
      send_sample(1'b1, 4095, 0, 255);
      send_sample(1'b1, 0, 4095, 255);
      send_sample(1'b1, 2048, 2048, 255);
      drain();

      // Fixed point at (100, 50): edge hits, point above the list
      write_reg(CSR_GAIN_X, 0, 20);
      write_reg(CSR_OFFSET_X, 100 << 16, 27);
      write_reg(CSR_GAIN_Y, 0, 20);
      write_reg(CSR_OFFSET_Y, (50 << 16) + 65535, 27);
      write_reg(CSR_SCAN_RECT, pack_box(100, 50, 0, 0), 36);
      write_reg(CSR_BACK_RECT, pack_box(101, 50, 5, 5), 36);
      write_reg(CSR_LIST_TOP, 60, 8);
      write_reg(CSR_ROW_HEIGHT, 1, 8);
      send_sample(1'b1, 1234, 2345, 255);
      drain();

      // Row equal to the count, then one below it
      write_reg(CSR_LIST_TOP, 0, 8);
      send_sample(1'b1, 77, 3000, 50);
      send_sample(1'b1, 3999, 5, 51);
      drain();

      // Floor of small negative and fractional values
      write_reg(CSR_GAIN_X, -1, 20);
      write_reg(CSR_OFFSET_X, 5 << 16, 27);
      write_reg(CSR_OFFSET_Y, -1, 27);
      send_sample(1'b1, 4095, 4095, 3);
      send_sample(1'b1, 1, 1, 3);
      drain();

      // Random phases, each with its own calibration
      for (int p = 0; p < PHASES; p++) begin
         random_calibration();
         start = samples_sent;
         while (samples_sent - start < PHASE_ITEMS) run_gesture();
         drain();
      end

      repeat (30) @(negedge clock);
      if (fail_count == 0 && points_pending == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
